FILE: rtl/core/pfe_pkg.sv
package pfe_pkg;

  // Fixed field widths and fixed-point formats.
  localparam int unsigned FEAT_W     = 24;
  localparam int unsigned VAL_W      = 48;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned X_FRAC     = 16;
  localparam int unsigned VAL_FRAC   = 24;
  localparam int unsigned LIN_SHIFT  = VAL_FRAC - X_FRAC;
  localparam int unsigned FIELD_NUM  = 5;
  localparam int unsigned OUT_LIMIT  = 55;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned DEG_W      = 2;
  localparam int unsigned CNT_W      = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEGREE        = 2'd0,
    CFG_FEATURE_COUNT = 2'd1,
    CFG_WITH_DERIV    = 2'd2
  } cfg_reg_e;

  typedef logic signed [FEAT_W-1:0] feat_t;
  typedef logic signed [VAL_W-1:0]  val_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam val_t ONE_Q24 = val_t'(1) <<< VAL_FRAC;

  // Request from the sequencer to the shared multiply unit.
  typedef struct packed {
    logic go;
    logic add_en;
  } mul_req_t;

endpackage

FILE: rtl/core/polynomial_feature_expansion_core.sv
// Expands each item of five signed Q8.16 features into its monomials of degree
// one up to the configured degree, in graded lexicographic order, as Q24.24
// values with optional partial derivatives. Raise start_i while busy_o is low;
// busy_o then stays high until the last term has been shown. Every term appears
// for exactly one cycle with term_valid_o and cannot be held off, so the
// receiver must take it in that cycle; last_term_o marks the final term. A
// degree-one term is shown from S_LIN, or with derivatives once S_LIN_G has
// walked every feature. Each higher term reads the stored suffix term, then
// waits for its product; with derivatives one product per feature follows
// (S_GRD, S_GGO, S_GMUL). A full item has up to 55 terms. The single 24x24
// multiplier is used twice per product and its result goes through rounding,
// saturation and the product-rule add. The scratch stores need no clearing
// pass. Configuration registers may only be written while busy_o is low.
module polynomial_feature_expansion_core #(
  parameter int unsigned MAX_DEGREE   = 3,
  parameter int unsigned NUM_FEATURES = 5,
  parameter int unsigned STORE_DEPTH  = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  pfe_pkg::feat_t                    feature_a_i,
  input  pfe_pkg::feat_t                    feature_b_i,
  input  pfe_pkg::feat_t                    feature_c_i,
  input  pfe_pkg::feat_t                    feature_d_i,
  input  pfe_pkg::feat_t                    feature_e_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pfe_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              term_valid_o,
  output logic [pfe_pkg::IDX_W-1:0]         term_index_o,
  output pfe_pkg::val_t                     term_value_o,
  output pfe_pkg::val_t                     grad_a_o,
  output pfe_pkg::val_t                     grad_b_o,
  output pfe_pkg::val_t                     grad_c_o,
  output pfe_pkg::val_t                     grad_d_o,
  output pfe_pkg::val_t                     grad_e_o,
  output logic                              last_term_o
);
  import pfe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LIN,
    S_LIN_G,
    S_TRD,
    S_TGO,
    S_TMUL,
    S_GRD,
    S_GGO,
    S_GMUL
  } seq_state_e;

  localparam int unsigned NF      = NUM_FEATURES;
  localparam int unsigned AW      = $clog2(STORE_DEPTH);
  localparam int unsigned GDEPTH  = STORE_DEPTH * NF;
  localparam int unsigned GAW     = $clog2(GDEPTH);
  localparam int unsigned JW      = (NF > 1) ? $clog2(NF) : 1;
  localparam int unsigned TOT1    = NF;
  localparam int unsigned TOT2    = TOT1 + NF * (NF + 1) / 2;
  localparam int unsigned TOT3    = TOT2 + NF * (NF + 1) * (NF + 2) / 6;
  localparam int unsigned LIM_CAP = (STORE_DEPTH < OUT_LIMIT) ? STORE_DEPTH : OUT_LIMIT;
  localparam logic [IDX_W-1:0] CAP1 = IDX_W'((TOT1 < LIM_CAP) ? TOT1 : LIM_CAP);
  localparam logic [IDX_W-1:0] CAP2 = IDX_W'((TOT2 < LIM_CAP) ? TOT2 : LIM_CAP);
  localparam logic [IDX_W-1:0] CAP3 = IDX_W'((TOT3 < LIM_CAP) ? TOT3 : LIM_CAP);
  localparam logic [DEG_W-1:0] DEG_TOP = DEG_W'(MAX_DEGREE);
  localparam logic [JW-1:0]    J_LAST  = JW'(NF - 1);

  function automatic logic [GAW-1:0] grad_addr(input logic [AW-1:0] row,
                                               input logic [JW-1:0] col);
    return GAW'(row) * GAW'(NF) + GAW'(col);
  endfunction

  // Configuration registers.
  logic [DEG_W-1:0] degree_q;
  logic [CNT_W-1:0] count_q;
  logic             deriv_q;

  // Sequencer state.
  seq_state_e       state_q;
  feat_t            x_q       [NF];
  logic [IDX_W-1:0] starts_q  [NF];
  logic [IDX_W-1:0] nstarts_q [NF];
  val_t             grad_q    [NF];
  logic [IDX_W-1:0] n_q;
  logic [IDX_W-1:0] cur_q;
  logic [IDX_W-1:0] k_q;
  logic [IDX_W-1:0] end_q;
  logic [JW-1:0]    f_q;
  logic [JW-1:0]    j_q;
  val_t             tk_q;
  val_t             tval_q;
  logic             term_valid_q;
  logic [IDX_W-1:0] term_index_q;
  val_t             term_value_q;
  logic             last_q;

  // Scratch stores.
  val_t             term_mem [STORE_DEPTH];
  val_t             grad_mem [GDEPTH];
  val_t             term_rd_q;
  val_t             grad_rd_q;

  feat_t            x_in [FIELD_NUM];
  val_t             grad_out [FIELD_NUM];
  feat_t            xf;
  val_t             lin_val;
  logic [DEG_W-1:0] deg_eff;
  logic [IDX_W-1:0] cap;
  logic [IDX_W-1:0] n_calc;
  logic             is_last;
  logic             emit;
  val_t             emit_val;
  logic             tw_en;
  val_t             tw_data;
  logic             gw_en;
  val_t             gw_data;
  logic [GAW-1:0]   gw_addr;
  logic [GAW-1:0]   gr_addr;
  mul_req_t         mul_req;
  logic             mul_done;
  val_t             mul_res;
  logic [IDX_W-1:0] cur_inc;

  assign x_in[0] = feature_a_i;
  assign x_in[1] = feature_b_i;
  assign x_in[2] = feature_c_i;
  assign x_in[3] = feature_d_i;
  assign x_in[4] = feature_e_i;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEG_W'(2);
      count_q  <= CNT_W'(20);
      deriv_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_DEGREE:        degree_q <= cfg_data_i[DEG_W-1:0];
        CFG_FEATURE_COUNT: count_q  <= cfg_data_i[CNT_W-1:0];
        CFG_WITH_DERIV:    deriv_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Number of terms for the item: degree clamped, then capped by the count.
  always_comb begin
    if (degree_q == '0) begin
      deg_eff = DEG_W'(1);
    end else if (degree_q > DEG_TOP) begin
      deg_eff = DEG_TOP;
    end else begin
      deg_eff = degree_q;
    end
    case (deg_eff)
      2'd1:    cap = CAP1;
      2'd2:    cap = CAP2;
      default: cap = CAP3;
    endcase
    n_calc = (IDX_W'(count_q) < cap) ? IDX_W'(count_q) : cap;
  end

  // Current feature and its degree-one term value.
  assign xf      = x_q[f_q];
  assign lin_val = {{(VAL_W-FEAT_W-LIN_SHIFT){xf[FEAT_W-1]}}, xf, {LIN_SHIFT{1'b0}}};
  assign is_last = (cur_q == n_q - IDX_W'(1));
  assign cur_inc = cur_q + IDX_W'(1);

  // A term is shown once its value and, if asked for, all derivatives are done.
  always_comb begin
    emit     = 1'b0;
    emit_val = tval_q;
    unique case (state_q)
      S_LIN: begin
        emit     = !deriv_q;
        emit_val = lin_val;
      end
      S_LIN_G: emit = (j_q == J_LAST);
      S_TMUL: begin
        emit     = mul_done && !deriv_q;
        emit_val = mul_res;
      end
      S_GMUL:  emit = mul_done && (j_q == J_LAST);
      default: ;
    endcase
  end

  // Store ports.
  assign tw_en   = (state_q == S_LIN) || ((state_q == S_TMUL) && mul_done);
  assign tw_data = (state_q == S_LIN) ? lin_val : mul_res;
  assign gw_en   = (state_q == S_LIN_G) || ((state_q == S_GMUL) && mul_done);
  assign gw_addr = grad_addr(cur_q[AW-1:0], j_q);
  assign gr_addr = grad_addr(k_q[AW-1:0], j_q);
  always_comb begin
    if (state_q == S_LIN_G) begin
      gw_data = (j_q == f_q) ? ONE_Q24 : '0;
    end else begin
      gw_data = mul_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tw_en) begin
      term_mem[cur_q[AW-1:0]] <= tw_data;
    end
    term_rd_q <= term_mem[k_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (gw_en) begin
      grad_mem[gw_addr] <= gw_data;
    end
    grad_rd_q <= grad_mem[gr_addr];
  end

  // Shared multiply unit.
  assign mul_req.go     = (state_q == S_TGO) || (state_q == S_GGO);
  assign mul_req.add_en = (state_q == S_GGO) && (j_q == f_q);

  pfe_mul_unit u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mul_req),
    .t_i      ((state_q == S_TGO) ? term_rd_q : grad_rd_q),
    .x_i      (xf),
    .addend_i (tk_q),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  // Sequencer: degree-one terms, then each level as a feature times a suffix
  // of the previous level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      n_q          <= '0;
      cur_q        <= '0;
      k_q          <= '0;
      end_q        <= '0;
      f_q          <= '0;
      j_q          <= '0;
      tk_q         <= '0;
      tval_q       <= '0;
      term_valid_q <= 1'b0;
      term_index_q <= '0;
      term_value_q <= '0;
      last_q       <= 1'b0;
      for (int i = 0; i < NF; i++) begin
        x_q[i]       <= '0;
        starts_q[i]  <= '0;
        nstarts_q[i] <= '0;
        grad_q[i]    <= '0;
      end
    end else begin
      term_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            for (int i = 0; i < NF; i++) begin
              x_q[i]      <= x_in[i];
              grad_q[i]   <= '0;
              starts_q[i] <= IDX_W'(i);
            end
            n_q     <= n_calc;
            cur_q   <= '0;
            k_q     <= '0;
            f_q     <= '0;
            j_q     <= '0;
            state_q <= (n_calc == '0) ? S_IDLE : S_LIN;
          end
        end
        S_LIN: begin
          tval_q <= lin_val;
          if (deriv_q) begin
            for (int i = 0; i < NF; i++) begin
              grad_q[i] <= (JW'(i) == f_q) ? ONE_Q24 : '0;
            end
            j_q     <= '0;
            state_q <= S_LIN_G;
          end
        end
        S_LIN_G: begin
          j_q <= j_q + JW'(1);
        end
        S_TRD: state_q <= S_TGO;
        S_TGO: begin
          tk_q    <= term_rd_q;
          state_q <= S_TMUL;
        end
        S_TMUL: begin
          if (mul_done) begin
            tval_q <= mul_res;
            if (deriv_q) begin
              j_q     <= '0;
              state_q <= S_GRD;
            end
          end
        end
        S_GRD: state_q <= S_GGO;
        S_GGO: state_q <= S_GMUL;
        S_GMUL: begin
          if (mul_done) begin
            grad_q[j_q] <= mul_res;
            j_q         <= j_q + JW'(1);
            state_q     <= S_GRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Show the finished term and move to the next one.
      if (emit) begin
        term_valid_q <= 1'b1;
        term_index_q <= cur_q;
        term_value_q <= emit_val;
        last_q       <= is_last;
        if (is_last) begin
          state_q <= S_IDLE;
        end else if ((state_q == S_LIN) || (state_q == S_LIN_G)) begin
          cur_q <= cur_inc;
          if (f_q == J_LAST) begin
            // Degree-one terms done: the second level starts.
            f_q          <= '0;
            k_q          <= starts_q[0];
            end_q        <= IDX_W'(NF);
            nstarts_q[0] <= cur_inc;
            state_q      <= S_TRD;
          end else begin
            f_q     <= f_q + JW'(1);
            state_q <= S_LIN;
          end
        end else begin
          cur_q   <= cur_inc;
          state_q <= S_TRD;
          if (k_q + IDX_W'(1) == end_q) begin
            if (f_q == J_LAST) begin
              // Level done: its segment starts become the suffix starts.
              for (int i = 0; i < NF; i++) begin
                starts_q[i] <= nstarts_q[i];
              end
              end_q        <= cur_inc;
              k_q          <= nstarts_q[0];
              f_q          <= '0;
              nstarts_q[0] <= cur_inc;
            end else begin
              f_q                     <= f_q + JW'(1);
              k_q                     <= starts_q[f_q + JW'(1)];
              nstarts_q[f_q + JW'(1)] <= cur_inc;
            end
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
      end
    end
  end

  // Derivative fields beyond the configured features read as zero.
  for (genvar g = 0; g < FIELD_NUM; g++) begin : g_grad
    if (g < NF) begin : g_used
      assign grad_out[g] = grad_q[g];
    end else begin : g_unused
      assign grad_out[g] = '0;
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign term_valid_o = term_valid_q;
  assign term_index_o = term_index_q;
  assign term_value_o = term_value_q;
  assign grad_a_o     = grad_out[0];
  assign grad_b_o     = grad_out[1];
  assign grad_c_o     = grad_out[2];
  assign grad_d_o     = grad_out[3];
  assign grad_e_o     = grad_out[4];
  assign last_term_o  = last_q;

  // The final term of an item leaves the block idle.
  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_valid_o && last_term_o |-> !busy_o)
    else $error("last term shown while still busy");

  // Any earlier term keeps the block busy.
  a_mid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_valid_o && !last_term_o |-> busy_o)
    else $error("block went idle before the last term");

  // The term position never reaches the term count while busy.
  a_cur_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (cur_q < n_q))
    else $error("term position beyond the term count");

  // Products only finish while the sequencer is waiting for one.
  a_mul_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_TMUL) || (state_q == S_GMUL))
    else $error("product finished outside a wait state");

endmodule

FILE: rtl/core/pfe_mul_unit.sv
module pfe_mul_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pfe_pkg::mul_req_t req_i,
  input  pfe_pkg::val_t    t_i,
  input  pfe_pkg::feat_t   x_i,
  input  pfe_pkg::val_t    addend_i,
  output logic             done_o,
  output pfe_pkg::val_t    result_o
);
  import pfe_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE,
    M_LO,
    M_HI,
    M_SUM,
    M_SAT,
    M_ADD
  } mul_state_e;

  localparam int unsigned HALF_W = VAL_W / 2;
  localparam int unsigned PP_W   = HALF_W + FEAT_W;
  localparam int unsigned HI_SH  = HALF_W - X_FRAC;
  localparam int unsigned Q_W    = PP_W + HI_SH + 1;
  localparam logic [Q_W-1:0] RND     = Q_W'(1) << (X_FRAC - 1);
  localparam logic [Q_W-1:0] NEG_LIM = Q_W'(1) << (VAL_W - 1);
  localparam logic [Q_W-1:0] POS_LIM = NEG_LIM - Q_W'(1);

  mul_state_e         state_q;
  logic               neg_q;
  logic               add_en_q;
  logic [VAL_W-1:0]   mt_q;
  logic [FEAT_W-1:0]  mx_q;
  val_t               addend_q;
  logic [PP_W-1:0]    pp_lo_q;
  logic [PP_W-1:0]    pp_hi_q;
  logic [Q_W-1:0]     q_q;
  val_t               prod_q;
  val_t               res_q;
  logic               done_q;

  logic [VAL_W-1:0]   t_mag;
  logic [FEAT_W-1:0]  x_mag;
  logic [HALF_W-1:0]  mul_a;
  logic [PP_W-1:0]    mul_p;
  logic [Q_W-1:0]     q_sum;
  val_t               sat_prod;
  logic signed [VAL_W:0] add_sum;
  val_t               sat_sum;

  // Operands are taken apart into sign and magnitude.
  assign t_mag = t_i[VAL_W-1] ? VAL_W'(-t_i) : VAL_W'(t_i);
  assign x_mag = x_i[FEAT_W-1] ? FEAT_W'(-x_i) : FEAT_W'(x_i);

  // The one multiplier: low half of the term first, then the high half.
  assign mul_a = (state_q == M_LO) ? mt_q[HALF_W-1:0] : mt_q[VAL_W-1:HALF_W];
  assign mul_p = PP_W'(mul_a) * PP_W'(mx_q);

  // Recombine the partial products with rounding half away from zero.
  assign q_sum = (Q_W'(pp_hi_q) << HI_SH) + ((Q_W'(pp_lo_q) + RND) >> X_FRAC);

  // Restore the sign and saturate to the 48-bit range.
  always_comb begin
    if (neg_q) begin
      sat_prod = (q_q > NEG_LIM) ? VAL_MIN : val_t'(-q_q[VAL_W-1:0]);
    end else begin
      sat_prod = (q_q > POS_LIM) ? VAL_MAX : val_t'(q_q[VAL_W-1:0]);
    end
  end

  // Product-rule addition with saturation.
  assign add_sum = {prod_q[VAL_W-1], prod_q} + {addend_q[VAL_W-1], addend_q};
  always_comb begin
    if (add_sum[VAL_W] != add_sum[VAL_W-1]) begin
      sat_sum = add_sum[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      sat_sum = add_sum[VAL_W-1:0];
    end
  end

  // Sequencing of one operation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= M_IDLE;
      neg_q    <= 1'b0;
      add_en_q <= 1'b0;
      mt_q     <= '0;
      mx_q     <= '0;
      addend_q <= '0;
      pp_lo_q  <= '0;
      pp_hi_q  <= '0;
      q_q      <= '0;
      prod_q   <= '0;
      res_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (req_i.go) begin
            neg_q    <= t_i[VAL_W-1] ^ x_i[FEAT_W-1];
            add_en_q <= req_i.add_en;
            mt_q     <= t_mag;
            mx_q     <= x_mag;
            addend_q <= addend_i;
            state_q  <= M_LO;
          end
        end
        M_LO: begin
          pp_lo_q <= mul_p;
          state_q <= M_HI;
        end
        M_HI: begin
          pp_hi_q <= mul_p;
          state_q <= M_SUM;
        end
        M_SUM: begin
          q_q     <= q_sum;
          state_q <= M_SAT;
        end
        M_SAT: begin
          if (add_en_q) begin
            prod_q  <= sat_prod;
            state_q <= M_ADD;
          end else begin
            res_q   <= sat_prod;
            done_q  <= 1'b1;
            state_q <= M_IDLE;
          end
        end
        M_ADD: begin
          res_q   <= sat_sum;
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
